// File: rtl/bnsf_pkg.sv
package bnsf_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  localparam int CFG_W    = 7;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 4;

  localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [COUNT_W-1:0] NEED_CORNER = 4'd2;
  localparam logic [COUNT_W-1:0] NEED_BORDER = 4'd4;
  localparam logic [COUNT_W-1:0] NEED_INNER  = 4'd6;

  // which neighbors of the output pixel lie inside the frame
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic lft_ok;
    logic rgt_ok;
  } edge_t;

  // one window column: bit 0 row above, bit 1 center row, bit 2 row below
  typedef logic [2:0] wcol_t;

endpackage

// File: rtl/bnsf_judge.sv
module bnsf_judge (
  input  bnsf_pkg::wcol_t lft,
  input  bnsf_pkg::wcol_t mid,
  input  bnsf_pkg::wcol_t rgt,
  input  bnsf_pkg::edge_t edges,
  output logic            hit
);

  logic [7:0]                   nbr;
  logic [bnsf_pkg::COUNT_W-1:0] count;
  logic [bnsf_pkg::COUNT_W-1:0] need;
  logic                         edge_r;
  logic                         edge_c;

  always_comb begin
    nbr[0] = lft[0] & edges.lft_ok & edges.top_ok;
    nbr[1] = lft[1] & edges.lft_ok;
    nbr[2] = lft[2] & edges.lft_ok & edges.bot_ok;
    nbr[3] = mid[0] & edges.top_ok;
    nbr[4] = mid[2] & edges.bot_ok;
    nbr[5] = rgt[0] & edges.rgt_ok & edges.top_ok;
    nbr[6] = rgt[1] & edges.rgt_ok;
    nbr[7] = rgt[2] & edges.rgt_ok & edges.bot_ok;
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + bnsf_pkg::COUNT_W'(nbr[i]);
    end
    edge_r = !edges.top_ok || !edges.bot_ok;
    edge_c = !edges.lft_ok || !edges.rgt_ok;
    if (edge_r && edge_c) begin
      need = bnsf_pkg::NEED_CORNER;
    end else if (edge_r || edge_c) begin
      need = bnsf_pkg::NEED_BORDER;
    end else begin
      need = bnsf_pkg::NEED_INNER;
    end
    hit = (count >= need);
  end

endmodule

// File: rtl/binary_neighbour_surround_filter.sv
// Binary neighbor surround filter.
// Input channel (in_valid/in_stall): one binary pixel per item, raster order,
// frame size from the frame_rows/frame_cols registers (0 acts as 1, values
// above the maximum are clamped). An item with drain set carries no pixel; it
// only pushes out pending results once the whole frame is in.
// Output channel (out_valid/out_stall): one result per pixel in raster order
// with its row/column and frame_last on the frame's final pixel. A result is
// due when the pixel diagonally below-right of it arrives, i.e. frame_cols+1
// pixels later; the last frame_cols+1 results need one drain item each.
// A result enters the read stage when the item that triggers it is accepted,
// then the output register. Throughput: one item per cycle while in_stall is
// low; the line store is a single column-wide memory read once per item and
// written once per pixel. Reset or a register write restarts the frame. When the
// receiver stalls, the result holds in the output register and one more result
// waits in the read stage; after that in_stall rises until the output is taken.
module binary_neighbour_surround_filter #(
  parameter int MAX_COLS = bnsf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = bnsf_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          pixel,
  input  logic                          drain,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          surrounded,
  output logic [bnsf_pkg::POS_W-1:0]    out_row,
  output logic [bnsf_pkg::POS_W-1:0]    out_col,
  output logic                          frame_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bnsf_pkg::ADDR_W-1:0]   paddr,
  input  logic [bnsf_pkg::DATA_W-1:0]   pwdata,
  output logic [bnsf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int AW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CCW  = $clog2(MAX_COLS + 1);
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int PW   = CCW + 1;
  localparam int ECW  = (CCW > bnsf_pkg::CFG_W) ? CCW : bnsf_pkg::CFG_W;
  localparam int ERW  = (RCW > bnsf_pkg::CFG_W) ? RCW : bnsf_pkg::CFG_W;

  // configuration
  logic [bnsf_pkg::CFG_W-1:0] frame_rows;
  logic [bnsf_pkg::CFG_W-1:0] frame_cols;
  logic                       cfg_we;
  logic [ERW-1:0]             rows_wide;
  logic [ECW-1:0]             cols_wide;
  logic [RCW-1:0]             rows_eff;
  logic [CCW-1:0]             cols_eff;

  // counters
  logic [RCW-1:0] in_row;
  logic [AW-1:0]  in_col;
  logic [RW-1:0]  out_rcnt;
  logic [AW-1:0]  out_ccnt;
  logic [PW-1:0]  pending;

  // line store ring: one bit per row slot (row mod 4)
  logic [3:0]     ring [MAX_COLS];
  logic [3:0]     rd_entry;
  logic [AW-1:0]  rd_addr;
  logic           fwd_hit;
  logic [1:0]     fwd_slot;
  logic           fwd_bit;
  logic [1:0]     boot;

  // read stage
  logic                  s1_valid;
  logic                  s1_first;
  logic                  s1_last;
  logic [1:0]            s1_base;
  bnsf_pkg::edge_t       s1_edges;
  logic [bnsf_pkg::POS_W-1:0] s1_row;
  logic [bnsf_pkg::POS_W-1:0] s1_col;
  bnsf_pkg::wcol_t       cur;
  bnsf_pkg::wcol_t       prev;

  logic            accept;
  logic            s1_move;
  logic            in_done;
  logic            is_pix;
  logic            emit;
  logic            at_last;
  logic            row_end;
  logic            in_row_end;
  bnsf_pkg::edge_t edges_now;
  logic [1:0]      base_now;
  logic [3:0]      entry_fix;
  bnsf_pkg::wcol_t nxt;
  bnsf_pkg::wcol_t cur_use;
  logic            hit;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[2])
      bnsf_pkg::REG_ROWS: prdata = bnsf_pkg::DATA_W'(frame_rows);
      bnsf_pkg::REG_COLS: prdata = bnsf_pkg::DATA_W'(frame_cols);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    rows_wide = ERW'(frame_rows);
    cols_wide = ECW'(frame_cols);
    if (frame_rows == '0) begin
      rows_eff = RCW'(1);
    end else if (rows_wide > ERW'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(rows_wide);
    end
    if (frame_cols == '0) begin
      cols_eff = CCW'(1);
    end else if (cols_wide > ECW'(MAX_COLS)) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(cols_wide);
    end
  end

  assign s1_move  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_done    = (in_row >= rows_eff);
    is_pix     = !in_done && !drain;
    emit       = in_done || (is_pix && ((pending + PW'(1)) >= (PW'(cols_eff) + PW'(2))));
    row_end    = (CCW'(out_ccnt) == cols_eff - CCW'(1));
    in_row_end = (CCW'(in_col) + CCW'(1) == cols_eff);
    at_last    = (RCW'(out_rcnt) == rows_eff - RCW'(1)) && row_end;
    edges_now.top_ok = (out_rcnt != '0);
    edges_now.bot_ok = (RCW'(out_rcnt) != rows_eff - RCW'(1));
    edges_now.lft_ok = (out_ccnt != '0);
    edges_now.rgt_ok = !row_end;
    // at a row end fetch column 0 of the next output row instead
    if (row_end) begin
      rd_addr  = '0;
      base_now = 2'(out_rcnt);
    end else begin
      rd_addr  = out_ccnt + AW'(1);
      base_now = 2'(out_rcnt) - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= bnsf_pkg::ROWS_RESET;
      frame_cols <= bnsf_pkg::COLS_RESET;
      in_row     <= '0;
      in_col     <= '0;
      out_rcnt   <= '0;
      out_ccnt   <= '0;
      pending    <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == bnsf_pkg::REG_ROWS) begin
        frame_rows <= pwdata[bnsf_pkg::CFG_W-1:0];
      end else begin
        frame_cols <= pwdata[bnsf_pkg::CFG_W-1:0];
      end
      in_row   <= '0;
      in_col   <= '0;
      out_rcnt <= '0;
      out_ccnt <= '0;
      pending  <= '0;
    end else if (accept) begin
      if (emit && at_last) begin
        in_row   <= '0;
        in_col   <= '0;
        out_rcnt <= '0;
        out_ccnt <= '0;
        pending  <= '0;
      end else begin
        if (is_pix) begin
          if (in_row_end) begin
            in_col <= '0;
            in_row <= in_row + RCW'(1);
          end else begin
            in_col <= in_col + AW'(1);
          end
        end
        if (emit) begin
          if (row_end) begin
            out_ccnt <= '0;
            out_rcnt <= out_rcnt + RW'(1);
          end else begin
            out_ccnt <= out_ccnt + AW'(1);
          end
        end
        pending <= pending + PW'(is_pix) - PW'(emit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_pix) begin
      ring[in_col][in_row[1:0]] <= pixel;
    end
    if (accept) begin
      rd_entry <= ring[rd_addr];
      fwd_hit  <= is_pix && (in_col == rd_addr);
      fwd_slot <= in_row[1:0];
      fwd_bit  <= pixel;
    end
    if (accept && is_pix && in_col == '0 && in_row == RCW'(0)) begin
      boot[0] <= pixel;
    end
    if (accept && is_pix && in_col == '0 && in_row == RCW'(1)) begin
      boot[1] <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= emit;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first <= (out_rcnt == '0) && (out_ccnt == '0);
      s1_last  <= at_last;
      s1_base  <= base_now;
      s1_edges <= edges_now;
      s1_row   <= bnsf_pkg::POS_W'(out_rcnt);
      s1_col   <= bnsf_pkg::POS_W'(out_ccnt);
    end
  end

  always_comb begin
    entry_fix = rd_entry;
    if (fwd_hit) begin
      entry_fix[fwd_slot] = fwd_bit;
    end
    nxt[0]  = entry_fix[s1_base];
    nxt[1]  = entry_fix[s1_base + 2'd1];
    nxt[2]  = entry_fix[s1_base + 2'd2];
    cur_use = s1_first ? {boot[1], boot[0], 1'b0} : cur;
  end

  bnsf_judge u_judge (
    .lft   (prev),
    .mid   (cur_use),
    .rgt   (nxt),
    .edges (s1_edges),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (s1_valid && s1_move) begin
      prev <= cur_use;
      cur  <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_move) begin
      surrounded <= hit;
      out_row    <= s1_row;
      out_col    <= s1_col;
      frame_last <= s1_last;
    end
  end

endmodule

// File: rtl/bnsf_checker.sv
module bnsf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       surrounded,
  input logic [bnsf_pkg::POS_W-1:0] out_row,
  input logic [bnsf_pkg::POS_W-1:0] out_col,
  input logic                       frame_last
);

  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side is free");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(surrounded) && $stable(out_row)
      && $stable(out_col) && $stable(frame_last)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_no_stall_after_reset: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind binary_neighbour_surround_filter bnsf_checker u_bnsf_checker (.*);
